// File: rtl/assert_macros.svh
// assertion helper macros for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/phtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phtc_pkg
// types and constants shared by the host traffic counter table
// ----------------------------------------------------------------------------
package phtc_pkg;
	localparam int unsigned DefaultEntries = 128;
	localparam logic [15:0] Ipv4Type = 16'h0800;
	localparam logic [47:0] ByteMax = {48{1'b1}};
	localparam logic [31:0] PktMax = {32{1'b1}};

	typedef struct packed {
		logic [15:0] frame_type;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] frame_length;
	} phtc_in_t;

	typedef struct packed {
		logic        counted;
		logic        source_ok;
		logic [6:0]  source_slot;
		logic [47:0] source_tx_total;
		logic [31:0] source_packet_total;
		logic [15:0] source_peak;
		logic        dest_ok;
		logic [6:0]  dest_slot;
		logic [47:0] dest_rx_total;
		logic [31:0] dest_packet_total;
		logic [15:0] dest_peak;
		logic [7:0]  entries_used;
	} phtc_out_t;

	// per-entry counters
	typedef struct packed {
		logic [31:0] addr;
		logic [47:0] tx;
		logic [47:0] rx;
		logic [31:0] pkt;
		logic [15:0] peak;
	} phtc_entry_t;

	// operation broadcast down the row of cells
	typedef struct packed {
		logic        valid;
		logic        is_tx;
		logic [31:0] addr;
		logic [15:0] len;
	} phtc_op_t;

	// result of one cell handed to its neighbor (first match wins)
	typedef struct packed {
		logic        hit;
		phtc_entry_t entry;
	} phtc_hit_t;

	function automatic phtc_entry_t phtc_apply(phtc_entry_t e, logic is_tx,
			logic [15:0] len);
		phtc_entry_t r;
		logic [48:0] s;
		r = e;
		s = {1'b0, (is_tx ? e.tx : e.rx)} + {33'd0, len};
		if (is_tx) r.tx = s[48] ? ByteMax : s[47:0];
		else r.rx = s[48] ? ByteMax : s[47:0];
		if (e.pkt != PktMax) r.pkt = e.pkt + 32'd1;
		if (len > e.peak) r.peak = len;
		return r;
	endfunction
endpackage

// File: rtl/phtc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phtc_cell
// one table entry: compare, update in place, pass the match result along
// ----------------------------------------------------------------------------
module phtc_cell import phtc_pkg::*; (
	input  logic        clk,
	input  phtc_op_t    op,
	input  logic        is_append,
	input  logic        in_use,
	input  phtc_hit_t   prev_hit,
	output phtc_hit_t   next_hit
);
	phtc_entry_t entry_q;
	logic        match;
	phtc_entry_t base;

	assign match = op.valid && in_use && (entry_q.addr == op.addr);

	// a fresh entry starts from zeroed counters
	always_comb begin
		base = entry_q;
		if (is_append) begin
			base = '0;
			base.addr = op.addr;
		end
	end

	always_ff @(posedge clk) begin
		if (op.valid && (match || is_append))
			entry_q <= phtc_apply(base, op.is_tx, op.len);
	end

	// chain result: pass on an earlier hit, else report this cell
	always_comb begin
		next_hit = prev_hit;
		if (!prev_hit.hit && (match || (op.valid && is_append))) begin
			next_hit.hit = 1'b1;
			next_hit.entry = phtc_apply(base, op.is_tx, op.len);
		end
	end
endmodule

// File: rtl/per_host_traffic_counter_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_host_traffic_counter_table
// per-host transmit/receive byte, packet and peak length accounting table
// ----------------------------------------------------------------------------
// channel  direction  payload     handshake
// in       input      phtc_in_t   in_valid / in_ready
// out      output     phtc_out_t  out_valid / out_ready
//
// an ipv4 request makes a source pass, then a destination pass that registers
// its result; other requests register theirs on acceptance. the next request
// is accepted only once the output register is empty or is being taken in that
// same cycle. each pass updates the row of cells, the hit travels to the end.
// reset clears the fill count and the control; entries need no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module per_host_traffic_counter_table import phtc_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = DefaultEntries
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  phtc_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output phtc_out_t out_data
);
	localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SRC, ST_DST} state_t;

	state_t          state_q;
	phtc_in_t        req_q;
	logic [CntW-1:0] used_q;
	phtc_out_t       res_q;
	logic            res_valid_q;
	phtc_out_t       res_d;
	logic            res_set;
	logic            accept;

	// hit chain between cells
	phtc_hit_t       chain [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES-1:0] hit_vec;
	logic [TABLE_ENTRIES-1:0] in_use_vec;
	phtc_op_t        op;
	logic            full;
	logic            found;
	logic [CntW-1:0] used_next;
	logic            ok;
	logic [IdxW-1:0] slot;

	// output register frees when taken or empty
	logic res_free;
	assign res_free = !res_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && res_free;
	assign out_valid = res_valid_q;
	assign out_data = res_q;
	assign accept = in_valid && in_ready;

	assign full = (used_q >= CntW'(TABLE_ENTRIES));

	always_comb begin
		op.valid = (state_q == ST_SRC) || (state_q == ST_DST);
		op.is_tx = (state_q == ST_SRC);
		op.addr = (state_q == ST_SRC) ? req_q.source_address : req_q.dest_address;
		op.len = req_q.frame_length;
	end

	assign chain[0] = '0;

	genvar g;
	generate
		for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
			logic in_use_g, app_g;
			assign in_use_g = (CntW'(g) < used_q);
			assign in_use_vec[g] = in_use_g;
			// the free cell at the fill count takes a missing address
			assign app_g = !full && (CntW'(g) == used_q);
			phtc_cell u_cell (
				.clk      (clk),
				.op       (op),
				.is_append(app_g),
				.in_use   (in_use_g),
				.prev_hit (chain[g]),
				.next_hit (chain[g+1])
			);
			assign hit_vec[g] = chain[g+1].hit && !chain[g].hit;
		end
	endgenerate

	// found: the first hit is an in-use cell, so nothing was appended
	assign found = |(hit_vec & in_use_vec);
	assign ok = chain[TABLE_ENTRIES].hit;

	always_comb begin
		slot = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (hit_vec[i]) slot = IdxW'(i);
	end

	assign used_next = (op.valid && ok && !found) ? used_q + CntW'(1) : used_q;

	// result set when a non-ipv4 request is taken or the destination pass ends
	assign res_set = (state_q == ST_DST) ||
		(accept && (in_data.frame_type != Ipv4Type));

	always_comb begin
		res_d = res_q;
		case (state_q)
			ST_IDLE: begin
				res_d = '0;
				res_d.entries_used = 8'(used_q);
			end
			ST_SRC: begin
				res_d = '0;
				res_d.counted = 1'b1;
				res_d.source_ok = ok;
				if (ok) begin
					res_d.source_slot = 7'(slot);
					res_d.source_tx_total = chain[TABLE_ENTRIES].entry.tx;
					res_d.source_packet_total = chain[TABLE_ENTRIES].entry.pkt;
					res_d.source_peak = chain[TABLE_ENTRIES].entry.peak;
				end
			end
			ST_DST: begin
				res_d.dest_ok = ok;
				if (ok) begin
					res_d.dest_slot = 7'(slot);
					res_d.dest_rx_total = chain[TABLE_ENTRIES].entry.rx;
					res_d.dest_packet_total = chain[TABLE_ENTRIES].entry.pkt;
					res_d.dest_peak = chain[TABLE_ENTRIES].entry.peak;
					// same address both ways: source fields see the second update
					if (res_q.source_ok &&
							(req_q.source_address == req_q.dest_address)) begin
						res_d.source_packet_total = chain[TABLE_ENTRIES].entry.pkt;
						res_d.source_peak = chain[TABLE_ENTRIES].entry.peak;
					end
				end
				res_d.entries_used = 8'(used_next);
			end
			default: res_d = res_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q <= '0;
			used_q <= '0;
			res_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			used_q <= used_next;
			res_valid_q <= res_set || (res_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q <= in_data;
						if (in_data.frame_type == Ipv4Type) begin
							state_q <= ST_SRC;
						end else begin
							res_q <= res_d;
						end
					end
				end
				ST_SRC: begin
					res_q <= res_d;
					state_q <= ST_DST;
				end
				ST_DST: begin
					res_q <= res_d;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_used_bound, clk, arst_n, used_q <= CntW'(TABLE_ENTRIES), "fill count overflow")
	`ASSERT_NEXT(a_dst_result, clk, arst_n, state_q == ST_DST, res_valid_q, "missing result")
	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, !(in_ready && state_q != ST_IDLE), "accept while busy")
endmodule

// File: tb/phtc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phtc_checker
// watches both channels, keeps its own host table and checks every result
// ----------------------------------------------------------------------------
module phtc_checker import phtc_pkg::*; #(
	parameter int unsigned ENTRIES = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  phtc_in_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  phtc_out_t out_data,
	output int        fail_count,
	output int        pending,
	output int        results_seen
);
	logic [31:0] host_addr [ENTRIES];
	logic [47:0] host_tx [ENTRIES];
	logic [47:0] host_rx [ENTRIES];
	logic [31:0] host_pkt [ENTRIES];
	logic [15:0] host_peak [ENTRIES];
	int unsigned host_used;
	phtc_out_t expected_results[$];

	function automatic int find_or_add(logic [31:0] a);
		for (int k = 0; k < host_used; k++)
			if (host_addr[k] == a) return k;
		if (host_used >= ENTRIES) return -1;
		host_addr[host_used] = a;
		host_tx[host_used] = '0;
		host_rx[host_used] = '0;
		host_pkt[host_used] = '0;
		host_peak[host_used] = '0;
		host_used++;
		return int'(host_used) - 1;
	endfunction

	function automatic void bump_host(int k, logic is_tx, logic [15:0] len);
		logic [48:0] s;
		s = {1'b0, (is_tx ? host_tx[k] : host_rx[k])} + {33'd0, len};
		if (is_tx) host_tx[k] = s[48] ? ByteMax : s[47:0];
		else host_rx[k] = s[48] ? ByteMax : s[47:0];
		if (host_pkt[k] != PktMax) host_pkt[k] = host_pkt[k] + 32'd1;
		if (len > host_peak[k]) host_peak[k] = len;
	endfunction

	function automatic phtc_out_t account_frame(phtc_in_t f);
		phtc_out_t r;
		int s, d;
		r = '0;
		if (f.frame_type == Ipv4Type) begin
			s = find_or_add(f.source_address);
			d = find_or_add(f.dest_address);
			if (s >= 0) bump_host(s, 1'b1, f.frame_length);
			if (d >= 0) bump_host(d, 1'b0, f.frame_length);
			r.counted = 1'b1;
			if (s >= 0) begin
				r.source_ok = 1'b1;
				r.source_slot = s[6:0];
				r.source_tx_total = host_tx[s];
				r.source_packet_total = host_pkt[s];
				r.source_peak = host_peak[s];
			end
			if (d >= 0) begin
				r.dest_ok = 1'b1;
				r.dest_slot = d[6:0];
				r.dest_rx_total = host_rx[d];
				r.dest_packet_total = host_pkt[d];
				r.dest_peak = host_peak[d];
			end
		end
		r.entries_used = host_used[7:0];
		return r;
	endfunction

	// one field compare, reports and returns 1 on mismatch
	function automatic bit check_field(string name, logic [47:0] e, logic [47:0] a);
		if (a !== e) begin
			$error("%s expected %0h actual %0h", name, e, a);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		phtc_out_t exp, got;
		bit bad;
		if (!arst_n) begin
			host_used = 0;
			fail_count = 0;
			results_seen = 0;
			expected_results.delete();
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(account_frame(in_data));
			if (out_valid && out_ready) begin
				results_seen++;
				got = out_data;
				if (expected_results.size() == 0) begin
					$error("result with no request waiting");
					fail_count++;
				end else begin
					exp = expected_results.pop_front();
					bad = 1'b0;
					bad = bad | check_field("counted", 48'(exp.counted),
						48'(got.counted));
					bad = bad | check_field("source_ok", 48'(exp.source_ok),
						48'(got.source_ok));
					bad = bad | check_field("source_slot", 48'(exp.source_slot),
						48'(got.source_slot));
					bad = bad | check_field("source_tx_total", exp.source_tx_total,
						got.source_tx_total);
					bad = bad | check_field("source_packet_total",
						48'(exp.source_packet_total), 48'(got.source_packet_total));
					bad = bad | check_field("source_peak", 48'(exp.source_peak),
						48'(got.source_peak));
					bad = bad | check_field("dest_ok", 48'(exp.dest_ok),
						48'(got.dest_ok));
					bad = bad | check_field("dest_slot", 48'(exp.dest_slot),
						48'(got.dest_slot));
					bad = bad | check_field("dest_rx_total", exp.dest_rx_total,
						got.dest_rx_total);
					bad = bad | check_field("dest_packet_total",
						48'(exp.dest_packet_total), 48'(got.dest_packet_total));
					bad = bad | check_field("dest_peak", 48'(exp.dest_peak),
						48'(got.dest_peak));
					bad = bad | check_field("entries_used", 48'(exp.entries_used),
						48'(got.entries_used));
					if (bad) fail_count++;
				end
			end
		end
		pending = expected_results.size();
	end
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the per-host traffic counter table
// ----------------------------------------------------------------------------
// directed frames cover field extremes, non-ipv4, same host both ways and
// saturation-sized lengths; random frames mostly draw from a small host pool
// until the table fills, then overflow it. idling runs through four phases.
// ----------------------------------------------------------------------------
module tb;
	import phtc_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	phtc_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	phtc_out_t out_data;
	int        fail_count, pending, results_seen;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	logic [31:0] host_pool [64];

	always #5 clk = ~clk;

	per_host_traffic_counter_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	phtc_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	// receiver stalls at random, changed only at the falling edge
	always @(negedge clk)
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);

	// offer one request and hold it until it is taken; valid stays high
	// into the next request unless the sender idles
	task automatic send_frame(logic [15:0] ft, logic [31:0] sa, logic [31:0] da,
			logic [15:0] len);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		end
		in_data <= '{frame_type: ft, source_address: sa, dest_address: da,
			frame_length: len};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// drop valid and wait until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// mostly well-formed ipv4 frames from a small pool, some noise
	task automatic random_frame(int pool_n);
		logic [15:0] ft;
		logic [31:0] sa, da;
		logic [15:0] len;
		ft = ($urandom_range(9) == 0) ? 16'($urandom) : Ipv4Type;
		sa = ($urandom_range(7) == 0) ? $urandom : host_pool[$urandom_range(pool_n - 1)];
		da = ($urandom_range(7) == 0) ? $urandom : host_pool[$urandom_range(pool_n - 1)];
		if ($urandom_range(9) == 0) da = sa;
		case ($urandom_range(3))
			0: len = 16'hffff;
			1: len = 16'($urandom_range(64, 1518));
			default: len = 16'($urandom);
		endcase
		send_frame(ft, sa, da, len);
	endtask

	initial begin
		int phase;
		for (int i = 0; i < 64; i++) host_pool[i] = $urandom;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		send_frame(16'h0000, 32'h0, 32'h0, 16'h0);
		send_frame(16'hffff, 32'hffffffff, 32'hffffffff, 16'hffff);
		send_frame(16'h0801, 32'h1, 32'h2, 16'd60);
		send_frame(Ipv4Type, 32'h0, 32'hffffffff, 16'h0);
		send_frame(Ipv4Type, 32'hffffffff, 32'h0, 16'hffff);
		send_frame(Ipv4Type, 32'hc0a80001, 32'hc0a80001, 16'd1500);
		send_frame(Ipv4Type, 32'hc0a80001, 32'h0a000001, 16'd64);
		send_frame(Ipv4Type, 32'h0a000001, 32'hc0a80001, 16'hffff);
		send_frame(Ipv4Type, 32'haaaaaaaa, 32'h55555555, 16'haaaa);
		send_frame(Ipv4Type, 32'h55555555, 32'haaaaaaaa, 16'h5555);
		send_frame(16'h86dd, 32'h12345678, 32'h9abcdef0, 16'd100);
		send_frame(Ipv4Type, 32'h0, 32'h0, 16'd1);

		// random part in four idling phases, the table fills during the first
		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? 70 : 0;
			recv_stall_pct = (phase == 2 || phase == 3) ? 70 : 0;
			if (phase == 3) begin
				send_idle_pct = 16;
				recv_stall_pct = 16;
			end
			for (int n = 0; n < 270; n++) begin
				// overflow the table with fresh addresses for the first 100 frames of phase one
				if (phase == 1 && n < 100)
					send_frame(Ipv4Type, $urandom, $urandom, 16'($urandom));
				else
					random_frame(phase == 0 ? 64 : 16);
			end
			// hold off until every result is back
			drain();
		end

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("sent directed and random frames over four idling phases, %0d results",
			results_seen);
		$display("covered non-ipv4, same host both ways, full table and peak updates");
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
